// ----- rtl/lft_pkg.sv -----
// lft_pkg: shared types and constants for the LRU frame tracker.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package lft_pkg;

    // Fixed field widths of the input and result beats
    localparam int IDX_W = 6;
    localparam int LRU_W = 6;

    // Default number of tracked frames
    localparam int NUM_FRAMES_DEF = 64;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINK
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/lft_if.sv -----
// lft_if: valid/ready channel interfaces for touch beats and result beats.
// Depends on lft_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lft_in_if import lft_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] frame_index;

    modport source (output valid, output frame_index, input ready);
    modport sink   (input valid, input frame_index, output ready);
endinterface

interface lft_out_if import lft_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LRU_W-1:0] lru_frame;
    logic             index_error;

    modport source (output valid, output lru_frame, output index_error, input ready);
    modport sink   (input valid, input lru_frame, input index_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/lft_link_ram.sv -----
// lft_link_ram: one link memory, one write and one read port, registered read.
// A read that hits the address written in the same cycle returns the new data.
// Depends on lft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lft_link_ram import lft_pkg::*; #(
    parameter int  DEPTH = NUM_FRAMES_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [AW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [AW-1:0] o_rdata
);

    logic [AW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_rdata;
    logic [AW-1:0] r_byp_data;
    logic          r_byp;

    // Storage array and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata    <= r_mem[i_raddr];
            r_byp_data <= i_wdata;
        end
    end

    // Same-address bypass flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_re) begin
            r_byp <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_byp ? r_byp_data : r_rdata;

endmodule

`default_nettype wire

// ----- rtl/lru_frame_tracker_top.sv -----
// lru_frame_tracker_top: LRU order of NUM_FRAMES frames as a doubly linked list.
// Depends on lft_pkg, lft_if (lft_in_if, lft_out_if) and lft_link_ram.
`timescale 1ns / 1ps
`default_nettype none

// The recency order lives in two link memories (toward older, toward newer)
// plus newest/oldest pointer registers. After reset the block runs a clearing
// pass that loads the initial order (frame NUM_FRAMES-1 newest down to frame 0
// oldest); no touch beat is accepted during it. A touch beat is taken only in
// the idle state with no result held, so not while the last one is unlinked:
// the accept step reads both links of the touched frame, the link step
// unlinks it, and the relink at the newest end is written while the next
// beat's links are read (same-address reads are bypassed). The pair of writes
// per link memory per touch over its single write port sets this split. The
// result beat (oldest frame after the update) is registered in the link step;
// one further result can be held while the output waits. An index of
// NUM_FRAMES or more flags index_error and leaves the order as it is.
module lru_frame_tracker_top import lft_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lft_in_if.sink    i_frame,
    lft_out_if.source o_lru
);

    localparam int FW = $clog2(NUM_FRAMES);
    localparam logic [FW+IDX_W-1:0] NUM_EXT = (FW + IDX_W)'(NUM_FRAMES);
    localparam logic [FW-1:0]       LAST    = FW'(NUM_FRAMES - 1);

    t_state r_state, n_state;

    logic [FW-1:0]  r_clr_cnt;
    logic [FW-1:0]  r_newest;
    logic [FW-1:0]  r_oldest;
    logic [FW-1:0]  r_cur;
    logic           r_cur_err;
    logic           r_wr2_pend;
    logic [FW-1:0]  r_wr2_frame;
    logic [FW-1:0]  r_wr2_prev;
    logic           r_res_pend;
    logic [FW-1:0]  r_res_oldest;
    logic           r_res_err;
    logic           r_out_valid;
    logic [FW-1:0]  r_out_oldest;
    logic           r_out_err;

    logic [FW+IDX_W-1:0] w_idx_ext;
    logic                w_in_err;
    logic [FW-1:0]       w_in_frame;
    logic                w_in_acc;
    logic                w_move;
    logic [FW-1:0]       w_older;
    logic [FW-1:0]       w_newer;
    logic [FW-1:0]       w_new_oldest;
    logic                w_out_free;
    logic [FW+LRU_W-1:0] w_lru_ext;

    logic          w_old_we;
    logic [FW-1:0] w_old_waddr;
    logic [FW-1:0] w_old_wdata;
    logic          w_new_we;
    logic [FW-1:0] w_new_waddr;
    logic [FW-1:0] w_new_wdata;

    // Input decode
    assign w_idx_ext  = {{FW{1'b0}}, i_frame.frame_index};
    assign w_in_err   = (w_idx_ext >= NUM_EXT);
    assign w_in_frame = w_in_err ? '0 : w_idx_ext[FW-1:0];
    assign i_frame.ready = (r_state == ST_IDLE) && !r_res_pend;
    assign w_in_acc   = i_frame.valid && i_frame.ready;

    // Link update decision for the frame under work
    assign w_move       = !r_cur_err && (r_cur != r_newest);
    assign w_new_oldest = (w_move && (r_cur == r_oldest)) ? w_newer : r_oldest;
    assign w_out_free   = !r_out_valid || o_lru.ready;

    // Write port steering: clearing pass, unlink, or relink
    always_comb begin
        w_old_we    = 1'b0;
        w_old_waddr = r_wr2_frame;
        w_old_wdata = r_wr2_prev;
        w_new_we    = 1'b0;
        w_new_waddr = r_wr2_prev;
        w_new_wdata = r_wr2_frame;
        if (r_state == ST_CLEAR) begin
            w_old_we    = 1'b1;
            w_old_waddr = r_clr_cnt;
            w_old_wdata = (r_clr_cnt == '0) ? LAST : r_clr_cnt - 1'b1;
            w_new_we    = 1'b1;
            w_new_waddr = r_clr_cnt;
            w_new_wdata = (r_clr_cnt == LAST) ? '0 : r_clr_cnt + 1'b1;
        end else if (r_state == ST_LINK) begin
            w_old_we    = w_move;
            w_old_waddr = w_newer;
            w_old_wdata = w_older;
            w_new_we    = w_move && (r_cur != r_oldest);
            w_new_waddr = w_older;
            w_new_wdata = w_newer;
        end else if (r_wr2_pend) begin
            w_old_we = 1'b1;
            w_new_we = 1'b1;
        end
    end

    lft_link_ram #(.DEPTH(NUM_FRAMES)) u_older_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_old_we),
        .i_waddr (w_old_waddr),
        .i_wdata (w_old_wdata),
        .i_re    (w_in_acc),
        .i_raddr (w_in_frame),
        .o_rdata (w_older)
    );

    lft_link_ram #(.DEPTH(NUM_FRAMES)) u_newer_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_new_we),
        .i_waddr (w_new_waddr),
        .i_wdata (w_new_wdata),
        .i_re    (w_in_acc),
        .i_raddr (w_in_frame),
        .o_rdata (w_newer)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_LINK;
                end
            end
            ST_LINK: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Clearing counter, pointers and relink bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_newest   <= LAST;
            r_oldest   <= '0;
            r_wr2_pend <= 1'b0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            r_wr2_pend <= 1'b0;
            if (r_state == ST_LINK && w_move) begin
                r_oldest   <= w_new_oldest;
                r_newest   <= r_cur;
                r_wr2_pend <= 1'b1;
            end
        end
    end

    // Beat under work and relink payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cur     <= w_in_frame;
            r_cur_err <= w_in_err;
        end
        if (r_state == ST_LINK) begin
            r_wr2_frame <= r_cur;
            r_wr2_prev  <= r_newest;
        end
    end

    // Result holding slot and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_lru.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_LINK) begin
                if (w_out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_res_pend <= 1'b1;
                end
            end else if (r_res_pend && w_out_free) begin
                r_out_valid <= 1'b1;
                r_res_pend  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LINK) begin
            r_res_oldest <= w_new_oldest;
            r_res_err    <= r_cur_err;
            if (w_out_free) begin
                r_out_oldest <= w_new_oldest;
                r_out_err    <= r_cur_err;
            end
        end else if (r_res_pend && w_out_free) begin
            r_out_oldest <= r_res_oldest;
            r_out_err    <= r_res_err;
        end
    end

    assign w_lru_ext         = {{LRU_W{1'b0}}, r_out_oldest};
    assign o_lru.valid       = r_out_valid;
    assign o_lru.lru_frame   = w_lru_ext[LRU_W-1:0];
    assign o_lru.index_error = r_out_err;

`ifndef SYNTH
    // Newest and oldest never coincide once the order is loaded
    a_ends_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |-> (r_newest != r_oldest))
        else $error("newest and oldest frame coincide");

    // A held result only exists behind an occupied output register
    a_res_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_pend |-> r_out_valid)
        else $error("held result with empty output register");

    // Every accepted touch is worked on in the next cycle
    a_acc_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_LINK))
        else $error("accepted touch not processed");

    // The relink write never overlaps the unlink step
    a_relink_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr2_pend |-> (r_state == ST_IDLE))
        else $error("relink write outside idle slot");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_lru_frame_tracker_top.sv -----
// tb_lru_frame_tracker_top: self-checking bench for lru_frame_tracker_top.
// Depends on lft_pkg, lft_if and the block; keeps its own copy of the recency list.
`timescale 1ns / 1ps

module tb_lru_frame_tracker_top;
    import lft_pkg::*;

    localparam int NUM_FRAMES  = NUM_FRAMES_DEF;
    localparam int RAND_TOUCH  = 1000;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int LONG_HOLD   = 100;

    typedef struct packed {
        logic [LRU_W-1:0] lru_frame;
        logic             index_error;
    } t_lru_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lft_in_if  frame_if ();
    lft_out_if lru_if ();

    lru_frame_tracker_top #(.NUM_FRAMES(NUM_FRAMES)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame_if),
        .o_lru   (lru_if)
    );

    // Clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Pending touches and the LRU results they should produce
    logic [IDX_W-1:0] touch_q [$];
    t_lru_beat        lru_expect_q [$];

    // Shadow recency list: links toward older / newer frames, plus end pointers
    int unsigned older_of [NUM_FRAMES];
    int unsigned newer_of [NUM_FRAMES];
    int unsigned mru_ptr;
    int unsigned lru_ptr;

    int n_touch, n_result, n_fail, n_repeat, n_oldest, n_long_holds, idle_cycles;

    function automatic int unsigned clamp_frame(int unsigned f);
        return (f < NUM_FRAMES) ? f : 0;
    endfunction

    // Move the touched frame to the MRU end; return the LRU frame afterwards
    function automatic t_lru_beat apply_touch(logic [IDX_W-1:0] idx);
        int unsigned f, prev, nxt;
        t_lru_beat   res;
        f = idx;
        res.index_error = (f >= NUM_FRAMES);
        if (!res.index_error && f != mru_ptr) begin
            prev = clamp_frame(older_of[f]);
            nxt  = clamp_frame(newer_of[f]);
            // unlink
            if (f == lru_ptr)
                lru_ptr = nxt;
            else
                newer_of[prev] = nxt;
            older_of[nxt] = prev;
            // relink at the newest end
            newer_of[clamp_frame(mru_ptr)] = f;
            older_of[f] = mru_ptr;
            mru_ptr = f;
        end
        res.lru_frame = lru_ptr[LRU_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers touches from touch_q with random gaps
    // ------------------------------------------------------------------
    int send_gap;
    bit send_burst;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_if.valid       <= 1'b0;
            frame_if.frame_index <= '0;
            send_gap = 0;
            send_burst = 1'b0;
        end else begin
            if (frame_if.valid && frame_if.ready) begin
                void'(touch_q.pop_front());
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 6);
            end
            if (frame_if.valid && !frame_if.ready) begin
                // hold the beat until taken
            end else if (send_gap == 0 && touch_q.size() > 0) begin
                frame_if.valid       <= 1'b1;
                frame_if.frame_index <= touch_q[0];
            end else begin
                frame_if.valid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls per result beat, plus two long hold-offs
    // ------------------------------------------------------------------
    int hold_cnt;
    int rcv_count;
    bit rcv_burst;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lru_if.ready <= 1'b0;
            hold_cnt = 0;
            rcv_count = 0;
            rcv_burst = 1'b0;
        end else if (hold_cnt > 0) begin
            lru_if.ready <= 1'b0;
            hold_cnt--;
        end else if (lru_if.valid && lru_if.ready) begin
            rcv_count++;
            if ($urandom_range(0, 39) == 0)
                rcv_burst = !rcv_burst;
            if (rcv_count == 300 || rcv_count == 700) begin
                // long hold-off so the block fills and backs up its input
                hold_cnt = LONG_HOLD;
                n_long_holds++;
            end else begin
                hold_cnt = rcv_burst ? 0 : $urandom_range(0, 6);
            end
            if (hold_cnt == 0) begin
                lru_if.ready <= 1'b1;
            end else begin
                lru_if.ready <= 1'b0;
                hold_cnt--;
            end
        end else begin
            lru_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each touch beat, check each result beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lru_beat want;
        if (i_rst_n) begin
            if (frame_if.valid && frame_if.ready) begin
                if (frame_if.frame_index == mru_ptr)
                    n_repeat++;
                if (frame_if.frame_index == lru_ptr)
                    n_oldest++;
                lru_expect_q.push_back(apply_touch(frame_if.frame_index));
                n_touch++;
            end
            if (lru_if.valid && lru_if.ready) begin
                n_result++;
                if (lru_expect_q.size() == 0) begin
                    $error("result beat with nothing expected: lru_frame %0d index_error %0d",
                           lru_if.lru_frame, lru_if.index_error);
                    n_fail++;
                end else begin
                    want = lru_expect_q.pop_front();
                    if (lru_if.lru_frame !== want.lru_frame) begin
                        $error("lru_frame: expected %0d, got %0d",
                               want.lru_frame, lru_if.lru_frame);
                        n_fail++;
                    end
                    if (lru_if.index_error !== want.index_error) begin
                        $error("index_error: expected %0d, got %0d",
                               want.index_error, lru_if.index_error);
                        n_fail++;
                    end
                end
            end
        end
        if ((frame_if.valid && frame_if.ready) || (lru_if.valid && lru_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    task automatic push_touch(input int unsigned f, inout int cnt);
        touch_q.push_back(f[IDX_W-1:0]);
        cnt++;
    endtask

    initial begin
        int unsigned directed [];
        int unsigned pool [4];
        int unsigned cur;
        int pick, run, step, k, n_rand, n_dummy;

        directed = '{63, 0, 0, 1, 32, 32, 62, 63, 5, 31, 42, 21,
                     2, 3, 4, 1, 0, 63, 62, 6, 7, 5, 42, 21, 2};

        frame_if.valid       = 1'b0;
        frame_if.frame_index = '0;
        lru_if.ready         = 1'b0;

        // reset order: frame NUM_FRAMES-1 newest down to frame 0 oldest
        for (int i = 0; i < NUM_FRAMES; i++) begin
            older_of[i] = (i + NUM_FRAMES - 1) % NUM_FRAMES;
            newer_of[i] = (i + 1) % NUM_FRAMES;
        end
        mru_ptr = NUM_FRAMES - 1;
        lru_ptr = 0;

        // directed: extremes, already-newest, oldest, middle frames, alternating bits
        n_dummy = 0;
        foreach (directed[i])
            push_touch(directed[i], n_dummy);

        // random: uniform, small working sets, repeats and sweeps
        n_rand = 0;
        cur = 0;
        while (n_rand < RAND_TOUCH) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                cur = $urandom_range(0, 63);
                push_touch(cur, n_rand);
            end else if (pick < 60) begin
                foreach (pool[i])
                    pool[i] = $urandom_range(0, 63);
                run = $urandom_range(4, 16);
                for (k = 0; k < run; k++) begin
                    cur = pool[$urandom_range(0, 3)];
                    push_touch(cur, n_rand);
                end
            end else if (pick < 75) begin
                run = $urandom_range(1, 3);
                for (k = 0; k < run; k++)
                    push_touch(cur, n_rand);
            end else begin
                cur  = $urandom_range(0, 63);
                step = $urandom_range(0, 1) ? 1 : 63;
                run  = $urandom_range(4, 20);
                for (k = 0; k < run; k++) begin
                    push_touch(cur, n_rand);
                    cur = (cur + step) % 64;
                end
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(touch_q.size() == 0 && !frame_if.valid && lru_expect_q.size() == 0)
               && idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);

        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d cycles with no beat accepted", idle_cycles);
            $display("CHECK FAILED");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            $display("touched %0d frames (%0d already newest, %0d were oldest), %0d results",
                     n_touch, n_repeat, n_oldest, n_result);
            $display("%0d long output hold-offs, %0d mismatches, %0d results left over",
                     n_long_holds, n_fail, lru_expect_q.size());
            if (n_fail == 0 && lru_expect_q.size() == 0)
                $display("CHECK OK");
            else
                $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/lft_pkg.sv
rtl/lft_if.sv
rtl/lft_link_ram.sv
rtl/lru_frame_tracker_top.sv
tb/tb_lru_frame_tracker_top.sv
